// ===== src/stbt_pkg.sv =====
// Package for the supertrend band tracker: widths, reset values, register
// indexes and the request payload structs. No dependencies.
package stbt_pkg;

  localparam int PRICE_WIDTH = 31;
  localparam int AVG_WIDTH   = 48;
  localparam int ATR_FRAC    = AVG_WIDTH - PRICE_WIDTH;
  localparam int BAND_WIDTH  = 32;
  localparam int ALPHA_WIDTH = 17;
  localparam int MULT_WIDTH  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE   = 17'd65536;
  localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET = 17'd4681;
  localparam logic [MULT_WIDTH-1:0]  MULT_RESET  = 16'd768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATR_ALPHA = 2'd0,
    CFG_BAND_MULT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic                   first_bar;
    logic [PRICE_WIDTH-1:0] high_price;
    logic [PRICE_WIDTH-1:0] low_price;
    logic [PRICE_WIDTH-1:0] close_price;
  } in_item_t;

  typedef struct packed {
    logic signed [BAND_WIDTH-1:0] trend_level;
    logic                         trend_down;
    logic [PRICE_WIDTH-1:0]       atr_value;
  } out_item_t;

endpackage

// ===== src/supertrend_band_tracker.sv =====
// Supertrend band tracker top level: sequencer around one shared multiplier.
// Depends on stbt_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) takes one price bar per
//   request. Output channel (out_valid_o/out_ready_i/out_item_o) returns one
//   result per bar: trend level, direction and ATR.
//   Config channel (cfg_valid_i/cfg_ready_o) writes atr_alpha (index 0) or
//   band_multiplier (index 1); other indexes are dropped. Always ready; write
//   only while no bar is in flight.
// Sequence:
//   An ordinary bar steps through the range, ATR low half, ATR high half,
//   update, band offset, band and trend states; a first bar skips the ATR
//   halves and the update. The steps are set by the single 32x17 multiplier:
//   ATR step low half, high half and the band offset product each take a
//   pass, plus range, update, band and trend steps around it.
//   in_ready_o is high only while the sequencer is idle.
// Reset: ATR, held bands, previous close clear; trend up; config at defaults; output empty.
// Stall: a result waits in the output register; the next bar may be taken
//   but its final step holds until the waiting result has gone.
module supertrend_band_tracker
  import stbt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_UPDATE,
    ST_MUL_BAND,
    ST_BAND,
    ST_TREND
  } state_e;

  localparam int OFF_W = MUL_P_W - 8;
  localparam int WIDE_W = OFF_W + 1;
  localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(64'sd2147483647);
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -WIDE_W'(64'sd2147483648);

  function automatic logic [PRICE_WIDTH-1:0] abs_diff(input logic [PRICE_WIDTH-1:0] a,
                                                      input logic [PRICE_WIDTH-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic signed [BAND_WIDTH-1:0] sat_band(
    input logic signed [WIDE_W-1:0] v);
    logic signed [BAND_WIDTH-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[BAND_WIDTH-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[BAND_WIDTH-1:0];
    end else begin
      r = v[BAND_WIDTH-1:0];
    end
    return r;
  endfunction

  state_e                        state_q;
  logic [ALPHA_WIDTH-1:0]        alpha_q;
  logic [MULT_WIDTH-1:0]         mult_q;
  in_item_t                      bar_q;
  logic [PRICE_WIDTH-1:0]        prev_close_q;
  logic [AVG_WIDTH-1:0]          avg_q;
  logic signed [BAND_WIDTH-1:0]  upper_q;
  logic signed [BAND_WIDTH-1:0]  lower_q;
  logic                          trend_up_q;
  logic [AVG_WIDTH-1:0]          diff_q;
  logic                          diff_neg_q;
  logic [MUL_B_W-1:0]            lo_part_q;
  logic [MUL_P_W-1:0]            step_q;
  logic [OFF_W-1:0]              off_q;
  logic signed [BAND_WIDTH-1:0]  up_band_q;
  logic signed [BAND_WIDTH-1:0]  lo_band_q;
  out_item_t                     out_q;
  logic                          out_valid_q;

  logic [ALPHA_WIDTH-1:0]        alpha_eff;
  logic [MUL_A_W-1:0]            mul_a;
  logic [MUL_B_W-1:0]            mul_b;
  logic [MUL_P_W-1:0]            mul_p;
  logic [PRICE_WIDTH-1:0]        tr_hl, tr_hp, tr_lp, tr_max;
  logic [AVG_WIDTH-1:0]          tr_ext;
  logic                          ext_ge;
  logic [MUL_B_W+15:0]           lo_sum;
  logic [MUL_P_W-1:0]            band_sum;
  logic [PRICE_WIDTH-1:0]        atr;
  logic [PRICE_WIDTH:0]          hl_sum;
  logic signed [WIDE_W-1:0]      mid_w, off_w;
  logic signed [BAND_WIDTH-1:0]  bu, bl, pc_s, cl_s;
  logic signed [BAND_WIDTH-1:0]  up_band_d, lo_band_d;
  logic                          trend_up_d;
  logic                          commit;

  assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign atr       = avg_q[AVG_WIDTH-1:ATR_FRAC];

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      ST_MUL_LO: begin
        mul_a = MUL_A_W'(diff_q[15:0]);
        mul_b = alpha_eff;
      end
      ST_MUL_HI: begin
        mul_a = diff_q[AVG_WIDTH-1:16];
        mul_b = alpha_eff;
      end
      ST_MUL_BAND: begin
        mul_a = MUL_A_W'(atr);
        mul_b = MUL_B_W'(mult_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  assign lo_sum   = mul_p[MUL_B_W+15:0] + (MUL_B_W+16)'(32768);
  assign band_sum = mul_p + MUL_P_W'(128);

  // true range against previous close
  always_comb begin
    tr_hl = abs_diff(bar_q.high_price, bar_q.low_price);
    tr_hp = abs_diff(bar_q.high_price, prev_close_q);
    tr_lp = abs_diff(bar_q.low_price, prev_close_q);
    tr_max = tr_hl;
    if (!bar_q.first_bar) begin
      if (tr_hp > tr_max) tr_max = tr_hp;
      if (tr_lp > tr_max) tr_max = tr_lp;
    end
  end

  assign tr_ext = {tr_max, {ATR_FRAC{1'b0}}};
  assign ext_ge = (tr_ext >= avg_q);

  // basic and ratcheted bands
  assign hl_sum = {1'b0, bar_q.high_price} + {1'b0, bar_q.low_price};
  assign mid_w  = $signed(WIDE_W'(hl_sum[PRICE_WIDTH:1]));
  assign off_w  = $signed({1'b0, off_q});
  assign bu     = sat_band(mid_w + off_w);
  assign bl     = sat_band(mid_w - off_w);
  assign pc_s   = $signed({1'b0, prev_close_q});
  assign cl_s   = $signed({1'b0, bar_q.close_price});

  always_comb begin
    if (bar_q.first_bar) begin
      up_band_d = bu;
      lo_band_d = bl;
    end else begin
      up_band_d = (bu < upper_q || pc_s > upper_q) ? bu : upper_q;
      lo_band_d = (bl > lower_q || pc_s < lower_q) ? bl : lower_q;
    end
  end

  always_comb begin
    priority if (bar_q.first_bar) begin
      trend_up_d = (cl_s <= up_band_q);
    end else if (trend_up_q) begin
      trend_up_d = !(cl_s < lo_band_q);
    end else begin
      trend_up_d = (cl_s > up_band_q);
    end
  end

  assign commit = (state_q == ST_TREND) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      alpha_q      <= ALPHA_RESET;
      mult_q       <= MULT_RESET;
      prev_close_q <= '0;
      avg_q        <= '0;
      upper_q      <= '0;
      lower_q      <= '0;
      trend_up_q   <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_ATR_ALPHA) begin
          alpha_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_BAND_MULT) begin
          mult_q <= cfg_data_i[MULT_WIDTH-1:0];
        end
      end

      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            bar_q   <= in_item_i;
            state_q <= ST_RANGE;
          end
        end
        ST_RANGE: begin
          if (bar_q.first_bar) begin
            avg_q   <= tr_ext;
            state_q <= ST_MUL_BAND;
          end else begin
            diff_q     <= ext_ge ? (tr_ext - avg_q) : (avg_q - tr_ext);
            diff_neg_q <= !ext_ge;
            state_q    <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: begin
          lo_part_q <= lo_sum[MUL_B_W+15:16];
          state_q   <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          step_q  <= mul_p + MUL_P_W'(lo_part_q);
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          avg_q   <= diff_neg_q ? (avg_q - step_q[AVG_WIDTH-1:0])
                                : (avg_q + step_q[AVG_WIDTH-1:0]);
          state_q <= ST_MUL_BAND;
        end
        ST_MUL_BAND: begin
          off_q   <= band_sum[MUL_P_W-1:8];
          state_q <= ST_BAND;
        end
        ST_BAND: begin
          up_band_q <= up_band_d;
          lo_band_q <= lo_band_d;
          state_q   <= ST_TREND;
        end
        ST_TREND: begin
          if (commit) begin
            upper_q                <= up_band_q;
            lower_q                <= lo_band_q;
            trend_up_q             <= trend_up_d;
            prev_close_q           <= bar_q.close_price;
            out_q.trend_level      <= trend_up_d ? lo_band_q : up_band_q;
            out_q.trend_down       <= !trend_up_d;
            out_q.atr_value        <= atr;
            state_q                <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== src/stbt_checker.sv =====
// Port-level checker for the supertrend band tracker, bound to the top level.
// Depends on stbt_pkg.
module stbt_checker
  import stbt_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input out_item_t             out_item_o,
  input logic                  cfg_ready_o
);

  // an accepted bar keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready straight after a bar was taken");

  // a new result only appears at the end of a busy spell
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a bar in flight");

  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result dropped or changed");

endmodule

bind supertrend_band_tracker stbt_checker u_stbt_checker (.*);

// ===== dv/supertrend_band_tracker_tb.sv =====
// Self-checking testbench for supertrend_band_tracker: drives price bars and
// register writes, predicts every result in-house and checks it field by field.
// Depends on stbt_pkg and the supertrend_band_tracker RTL.
module supertrend_band_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stbt_pkg::*;

  localparam logic [PRICE_WIDTH-1:0] PRICE_TOP = '1;
  localparam longint                 PRICE_MAX = (64'd1 << PRICE_WIDTH) - 1;
  localparam logic [CFG_IDX_W-1:0]   CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0]   CFG_SPARE_3 = 2'd3;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 200;
  localparam int BARS_PER_PHASE = 200;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_item_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // predictor state and register copies
  logic [ALPHA_WIDTH-1:0] alpha_reg;
  logic [MULT_WIDTH-1:0]  mult_reg;
  logic [PRICE_WIDTH-1:0] prev_close;
  logic [AVG_WIDTH-1:0]   avg_range;
  longint                 upper_hold;
  longint                 lower_hold;
  logic                   trend_up;

  out_item_t   trend_q[$];
  int          err_count = 0;
  int          quiet_cycles = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit          rx_hold_req = 1'b0;
  longint      walk_px;

  supertrend_band_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] abs_gap(input logic [63:0] a, input logic [63:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // round-half-up of x * a / 2^16, split so the product never overflows
  function automatic logic [63:0] scale_q16(input logic [63:0] x, input logic [63:0] a);
    return (x >> 16) * a + (((x & 64'hFFFF) * a + 64'd32768) >> 16);
  endfunction

  function automatic longint clamp_band(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_price(input longint v);
    if (v < 0) return 0;
    if (v > PRICE_MAX) return PRICE_MAX;
    return v;
  endfunction

  function automatic out_item_t predict_trend(input in_item_t bar);
    logic [63:0] hi, lo, cl, alpha, range, ext, avg, atr, offset;
    longint      mid, band_hi, band_lo, upper_band, lower_band, pc;
    logic        up;
    out_item_t   res;
    hi    = 64'(bar.high_price);
    lo    = 64'(bar.low_price);
    cl    = 64'(bar.close_price);
    alpha = (alpha_reg > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_reg);
    range = abs_gap(hi, lo);
    avg   = 64'(avg_range);
    if (bar.first_bar) begin
      avg = range << ATR_FRAC;
    end else begin
      if (abs_gap(hi, 64'(prev_close)) > range) range = abs_gap(hi, 64'(prev_close));
      if (abs_gap(lo, 64'(prev_close)) > range) range = abs_gap(lo, 64'(prev_close));
      ext = range << ATR_FRAC;
      if (ext >= avg) avg = avg + scale_q16(ext - avg, alpha);
      else avg = avg - scale_q16(avg - ext, alpha);
    end
    atr     = avg >> ATR_FRAC;
    offset  = (atr * 64'(mult_reg) + 64'd128) >> 8;
    mid     = longint'((hi + lo) >> 1);
    band_hi = clamp_band(mid + longint'(offset));
    band_lo = clamp_band(mid - longint'(offset));
    pc      = longint'(64'(prev_close));
    if (bar.first_bar) begin
      upper_band = band_hi;
      lower_band = band_lo;
      up = (longint'(cl) <= upper_band);
    end else begin
      // ratchet: a band only loosens once the previous close has crossed it
      upper_band = (band_hi < upper_hold || pc > upper_hold) ? band_hi : upper_hold;
      lower_band = (band_lo > lower_hold || pc < lower_hold) ? band_lo : lower_hold;
      if (trend_up) up = !(longint'(cl) < lower_band);
      else up = (longint'(cl) > upper_band);
    end
    avg_range  = avg[AVG_WIDTH-1:0];
    upper_hold = upper_band;
    lower_hold = lower_band;
    trend_up   = up;
    prev_close = bar.close_price;
    res.trend_level = 32'(up ? lower_band : upper_band);
    res.trend_down  = ~up;
    res.atr_value   = (atr > 64'h7FFF_FFFF) ? '1 : atr[PRICE_WIDTH-1:0];
    return res;
  endfunction

  function automatic in_item_t make_bar(input logic first, input logic [PRICE_WIDTH-1:0] hi,
                                        input logic [PRICE_WIDTH-1:0] lo,
                                        input logic [PRICE_WIDTH-1:0] cl);
    in_item_t b;
    b.first_bar   = first;
    b.high_price  = hi;
    b.low_price   = lo;
    b.close_price = cl;
    return b;
  endfunction

  // Mostly a random walk of well-formed bars; some bars are pure noise and
  // some have low and high swapped.
  function automatic in_item_t next_bar(input bit start);
    in_item_t    b;
    longint      spread, h, l, c, t;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 6 && !start) begin
      b.first_bar   = 1'($urandom_range(0, 1));
      b.high_price  = PRICE_WIDTH'($urandom);
      b.low_price   = PRICE_WIDTH'($urandom);
      b.close_price = PRICE_WIDTH'($urandom);
      return b;
    end
    b.first_bar = start || ($urandom_range(0, 39) == 0);
    if (b.first_bar)
      walk_px = longint'($urandom_range(0, 32'h7FFF_FFFF)) >> $urandom_range(0, 28);
    spread  = walk_px / 64 + 32;
    walk_px = walk_px + longint'($urandom_range(0, 2 * spread)) - spread;
    if ($urandom_range(0, 19) == 0)
      walk_px = walk_px + (($urandom_range(0, 1) != 0) ? 8 * spread : -8 * spread);
    walk_px = clamp_price(walk_px);
    h = clamp_price(walk_px + longint'($urandom_range(0, spread)));
    l = clamp_price(walk_px - longint'($urandom_range(0, spread)));
    c = l + longint'($urandom_range(0, h - l));
    if (pick < 12) begin
      t = h;
      h = l;
      l = t;
    end
    b.high_price  = PRICE_WIDTH'(h);
    b.low_price   = PRICE_WIDTH'(l);
    b.close_price = PRICE_WIDTH'(c);
    return b;
  endfunction

  task automatic send_bar(input in_item_t bar);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= bar;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    trend_q = {trend_q, predict_trend(bar)};
  endtask

  task automatic run_series(input int count);
    for (int i = 0; i < count; i++) send_bar(next_bar(1'b0));
  endtask

  // drop valid and wait until every outstanding result has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (trend_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_ATR_ALPHA: alpha_reg = data;
      CFG_BAND_MULT: mult_reg = data[MULT_WIDTH-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_registers(input logic [CFG_DATA_W-1:0] alpha,
                               input logic [CFG_DATA_W-1:0] mult);
    settle();
    write_reg(CFG_ATR_ALPHA, alpha);
    write_reg(CFG_BAND_MULT, mult);
  endtask

  task automatic test_directed_bars();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // bars before any series start run against the cleared state
    send_bar(make_bar(1'b0, '0, '0, '0));
    send_bar(make_bar(1'b0, 31'd2560, 31'd2304, 31'd2432));
    send_bar(make_bar(1'b0, 31'd2304, 31'd2560, 31'd2400));
    send_bar(make_bar(1'b1, '0, '0, '0));
    send_bar(make_bar(1'b1, PRICE_TOP, PRICE_TOP, PRICE_TOP));
    // full range on a first bar: both bands clip
    send_bar(make_bar(1'b1, PRICE_TOP, '0, PRICE_TOP));
    send_bar(make_bar(1'b0, '0, PRICE_TOP, '0));
    // first bar closing above / exactly on the upper band
    send_bar(make_bar(1'b1, 31'd25600, 31'd25600, 31'd25857));
    send_bar(make_bar(1'b1, 31'd25600, 31'd25600, 31'd25600));
    send_bar(make_bar(1'b0, 31'd25600, 31'd25600, 31'd25600));
    // sharp drop then sharp rally to flip the trend both ways
    send_bar(make_bar(1'b1, 31'd25700, 31'd25500, 31'd25600));
    send_bar(make_bar(1'b0, 31'd25650, 31'd25550, 31'd25600));
    send_bar(make_bar(1'b0, 31'd25600, 31'd20000, 31'd20100));
    send_bar(make_bar(1'b0, 31'd20200, 31'd20000, 31'd20100));
    send_bar(make_bar(1'b0, 31'd31000, 31'd20100, 31'd30900));
    send_bar(make_bar(1'b0, 31'd30950, 31'd30850, 31'd30900));
    send_bar(make_bar(1'b0, PRICE_TOP, PRICE_TOP, PRICE_TOP));
    send_bar(make_bar(1'b0, '0, '0, '0));
    send_bar(make_bar(1'b1, 31'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555));
    send_bar(make_bar(1'b0, 31'h2AAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA));
  endtask

  task automatic test_register_extremes();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // zero alpha: ATR only moves on first bars
    set_registers('0, 17'hFFFF);
    send_bar(make_bar(1'b1, 31'd51200, 31'd50000, 31'd50500));
    run_series(10);
    // full-weight smoothing and widest multiplier; second bar clips both bands
    set_registers(ALPHA_ONE, 17'hFFFF);
    send_bar(make_bar(1'b1, PRICE_TOP, PRICE_TOP, PRICE_TOP));
    send_bar(make_bar(1'b0, '0, '0, '0));
    run_series(8);
    // alpha above one saturates, zero multiplier collapses bands onto midpoint
    set_registers('1, '0);
    send_bar(next_bar(1'b1));
    run_series(8);
    // multiplier register keeps only its low 16 bits
    set_registers(17'd1, 17'h1_0100);
    send_bar(next_bar(1'b1));
    run_series(8);
    // unused indexes leave both registers alone
    settle();
    write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_3, '1);
    send_bar(next_bar(1'b1));
    run_series(8);
    set_registers(ALPHA_RESET, CFG_DATA_W'(MULT_RESET));
  endtask

  task automatic test_output_hold_off();
    settle();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_req  = 1'b1;
    send_bar(next_bar(1'b1));
    run_series(11);
    settle();
  endtask

  task automatic test_random_series();
    int unsigned tx_pct[4] = '{0, 71, 0, 38};
    int unsigned rx_pct[4] = '{0, 0, 71, 38};
    logic [CFG_DATA_W-1:0] alpha;
    for (int p = 0; p < 4; p++) begin
      if ($urandom_range(0, 3) == 0) alpha = CFG_DATA_W'($urandom_range(1, 65536));
      else alpha = CFG_DATA_W'(65536 / $urandom_range(2, 40));
      set_registers(alpha, CFG_DATA_W'($urandom_range(0, 1536)));
      tx_idle_pct  = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      send_bar(next_bar(1'b1));
      run_series(BARS_PER_PHASE);
    end
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin : drive_out_ready
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (trend_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: result with none expected, expected nothing, got %h",
                   $time, out_item_o);
      end else begin
        want = trend_q.pop_front();
        if (want.trend_level !== out_item_o.trend_level)
          flag_mismatch("trend_level", want.trend_level, out_item_o.trend_level);
        if (want.trend_down !== out_item_o.trend_down)
          flag_mismatch("trend_down", 32'(want.trend_down), 32'(out_item_o.trend_down));
        if (want.atr_value !== out_item_o.atr_value)
          flag_mismatch("atr_value", 32'(want.atr_value), 32'(out_item_o.atr_value));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("supertrend_band_tracker_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ATR_ALPHA;
    cfg_data_i  = '0;
    alpha_reg   = ALPHA_RESET;
    mult_reg    = MULT_RESET;
    prev_close  = '0;
    avg_range   = '0;
    upper_hold  = 0;
    lower_hold  = 0;
    trend_up    = 1'b1;
    walk_px     = 64'd25600;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_bars();
    test_register_extremes();
    test_output_hold_off();
    test_random_series();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && trend_q.size() == 0)
      $display("supertrend_band_tracker_tb: done, clean");
    else
      $display("supertrend_band_tracker_tb: done, errors");
    $finish;
  end

endmodule
